@@ sv/aarm_pkg.sv @@
// Shared constants and helpers for the axis-angle to rotation matrix core.
`default_nettype none
package aarm_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned XW = 33;
  localparam int unsigned ZW = 34;
  localparam int unsigned QW = 32;
  localparam int unsigned PW = 64;
  localparam int unsigned EW = 67;
  localparam int unsigned SIDE_W = 49;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [35:0] RAD_PER_UNIT = 36'sd146409;
  localparam logic signed [16:0] HALF_TURN = 17'sd23040;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;
  localparam logic signed [16:0] FULL_TURN = 17'sd46080;

  typedef logic signed [15:0] q15_t;

  function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic q15_t sat_q15(input logic signed [EW-1:0] e);
    logic signed [EW-1:0] r;
    q15_t o;
    r = (e + (67'sd1 <<< 44)) >>> 45;
    if (r > 67'sd32767) begin
      o = 16'sh7fff;
    end else if (r < -67'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ sv/aarm_cordic.sv @@
// Pipelined rotation-mode CORDIC, one register stage per iteration.
`default_nettype none
module aarm_cordic #(
  parameter int unsigned CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  en,
  input  wire                                  in_valid,
  input  wire  signed [aarm_pkg::ZW-1:0]       in_z,
  input  wire         [aarm_pkg::SIDE_W-1:0]   in_side,
  output logic                                 out_valid,
  output logic signed [aarm_pkg::XW-1:0]       out_x,
  output logic signed [aarm_pkg::XW-1:0]       out_y,
  output logic        [aarm_pkg::SIDE_W-1:0]   out_side
);
  import aarm_pkg::*;

  localparam int unsigned NS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  logic                    v_r    [NS];
  logic signed [XW-1:0]    x_r    [NS];
  logic signed [XW-1:0]    y_r    [NS];
  logic signed [ZW-1:0]    z_r    [NS];
  logic [SIDE_W-1:0]       side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic                 vi;
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic [SIDE_W-1:0]    si;
    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = in_z;
      assign si = in_side;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
      assign si = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= si;
        if (zi >= 0) begin
          x_r[k] <= xi - (yi >>> k);
          y_r[k] <= yi + (xi >>> k);
          z_r[k] <= zi - atan_val(k);
        end else begin
          x_r[k] <= xi + (yi >>> k);
          y_r[k] <= yi - (xi >>> k);
          z_r[k] <= zi + atan_val(k);
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_x     = x_r[NS-1];
  assign out_y     = y_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire

@@ sv/axis_angle_to_rotation_matrix_core.sv @@
// Throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and out_ready is low.
// The CORDIC runs one iteration per stage; the multiplies take three stages.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
`default_nettype none
module axis_angle_to_rotation_matrix_core #(
  parameter int unsigned CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  aarm_pkg::q15_t  in_axis_x,
  input  wire  aarm_pkg::q15_t  in_axis_y,
  input  wire  aarm_pkg::q15_t  in_axis_z,
  input  wire  aarm_pkg::q15_t  in_angle_deg,
  output logic                  out_valid,
  input  wire                   out_ready,
  output aarm_pkg::q15_t        out_m00,
  output aarm_pkg::q15_t        out_m01,
  output aarm_pkg::q15_t        out_m02,
  output aarm_pkg::q15_t        out_m10,
  output aarm_pkg::q15_t        out_m11,
  output aarm_pkg::q15_t        out_m12,
  output aarm_pkg::q15_t        out_m20,
  output aarm_pkg::q15_t        out_m21,
  output aarm_pkg::q15_t        out_m22
);
  import aarm_pkg::*;

  logic en;
  logic vo_r;
  assign en       = !vo_r || out_ready;
  assign in_ready = en;

  // input register
  logic v0_r;
  q15_t ax0_r, ay0_r, az0_r, ang0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax0_r  <= in_axis_x;
      ay0_r  <= in_axis_y;
      az0_r  <= in_axis_z;
      ang0_r <= in_angle_deg;
    end
  end

  // wrap, fold and scale to radians
  logic signed [16:0] aw, af;
  logic               neg_nxt;
  logic signed [35:0] zp;
  always_comb begin
    aw = 17'(ang0_r);
    if (aw >= HALF_TURN) begin
      aw = aw - FULL_TURN;
    end else if (aw < -HALF_TURN) begin
      aw = aw + FULL_TURN;
    end
    af      = aw;
    neg_nxt = 1'b0;
    if (aw > QUARTER_TURN) begin
      af      = HALF_TURN - aw;
      neg_nxt = 1'b1;
    end else if (aw < -QUARTER_TURN) begin
      af      = -HALF_TURN - aw;
      neg_nxt = 1'b1;
    end
    zp = 36'(af) * RAD_PER_UNIT;
  end

  logic                v1_r;
  logic signed [ZW-1:0] z1_r;
  logic [SIDE_W-1:0]   side1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z1_r    <= ZW'(zp);
      side1_r <= {neg_nxt, ax0_r, ay0_r, az0_r};
    end
  end

  logic                 vc;
  logic signed [XW-1:0] xc, yc;
  logic [SIDE_W-1:0]    sidec;

  aarm_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .in_z      (z1_r),
    .in_side   (side1_r),
    .out_valid (vc),
    .out_x     (xc),
    .out_y     (yc),
    .out_side  (sidec)
  );

  // quaternion
  q15_t                 cax, cay, caz;
  logic                 cneg;
  logic signed [XW-1:0] cw;
  logic signed [48:0]   pqx, pqy, pqz;
  assign cneg = sidec[48];
  assign cax  = sidec[47:32];
  assign cay  = sidec[31:16];
  assign caz  = sidec[15:0];
  assign cw   = cneg ? -xc : xc;
  assign pqx  = 49'(cax) * 49'(yc);
  assign pqy  = 49'(cay) * 49'(yc);
  assign pqz  = 49'(caz) * 49'(yc);

  logic                 vq_r;
  logic signed [QW-1:0] qx_r, qy_r, qz_r, qw_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (en) begin
      vq_r <= vc;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= QW'((pqx + 49'sd16384) >>> 15);
      qy_r <= QW'((pqy + 49'sd16384) >>> 15);
      qz_r <= QW'((pqz + 49'sd16384) >>> 15);
      qw_r <= QW'(cw);
    end
  end

  // products
  logic                 vp_r;
  logic signed [PW-1:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r, pwx_r, pwy_r, pwz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= vq_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= PW'(qx_r) * PW'(qx_r);
      pyy_r <= PW'(qy_r) * PW'(qy_r);
      pzz_r <= PW'(qz_r) * PW'(qz_r);
      pxy_r <= PW'(qx_r) * PW'(qy_r);
      pxz_r <= PW'(qx_r) * PW'(qz_r);
      pyz_r <= PW'(qy_r) * PW'(qz_r);
      pwx_r <= PW'(qw_r) * PW'(qx_r);
      pwy_r <= PW'(qw_r) * PW'(qy_r);
      pwz_r <= PW'(qw_r) * PW'(qz_r);
    end
  end

  // sums, round and saturate
  logic signed [EW-1:0] one;
  logic signed [EW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  always_comb begin
    one = 67'sd1 <<< 60;
    e00 = one - ((EW'(pyy_r) + EW'(pzz_r)) <<< 1);
    e01 = (EW'(pxy_r) - EW'(pwz_r)) <<< 1;
    e02 = (EW'(pxz_r) + EW'(pwy_r)) <<< 1;
    e10 = (EW'(pxy_r) + EW'(pwz_r)) <<< 1;
    e11 = one - ((EW'(pxx_r) + EW'(pzz_r)) <<< 1);
    e12 = (EW'(pyz_r) - EW'(pwx_r)) <<< 1;
    e20 = (EW'(pxz_r) - EW'(pwy_r)) <<< 1;
    e21 = (EW'(pyz_r) + EW'(pwx_r)) <<< 1;
    e22 = one - ((EW'(pxx_r) + EW'(pyy_r)) <<< 1);
  end

  q15_t m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vp_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m00_r <= sat_q15(e00);
      m01_r <= sat_q15(e01);
      m02_r <= sat_q15(e02);
      m10_r <= sat_q15(e10);
      m11_r <= sat_q15(e11);
      m12_r <= sat_q15(e12);
      m20_r <= sat_q15(e20);
      m21_r <= sat_q15(e21);
      m22_r <= sat_q15(e22);
    end
  end

  assign out_valid = vo_r;
  assign out_m00   = m00_r;
  assign out_m01   = m01_r;
  assign out_m02   = m02_r;
  assign out_m10   = m10_r;
  assign out_m11   = m11_r;
  assign out_m12   = m12_r;
  assign out_m20   = m20_r;
  assign out_m21   = m21_r;
  assign out_m22   = m22_r;

endmodule
`default_nettype wire

@@ verif/tb_axis_angle_to_rotation_matrix_core.sv @@
// Testbench for the axis-angle to rotation matrix core: table plus random beats.
`default_nettype none
module tb_axis_angle_to_rotation_matrix_core;
  import aarm_pkg::*;

  typedef struct packed {
    q15_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } rot_mat_t;

  typedef struct packed {
    q15_t ax, ay, az, ang;
    logic has_mat;
    rot_mat_t mat;
  } stim_row_t;

  localparam rot_mat_t IDENT = '{16'sh7fff, 16'sh0, 16'sh0, 16'sh0, 16'sh7fff, 16'sh0,
                                 16'sh0, 16'sh0, 16'sh7fff};
  localparam int N_RAND = 1530;
  localparam int LAT = CORDIC_STEPS_DEF + 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  q15_t in_axis_x = '0, in_axis_y = '0, in_axis_z = '0, in_angle_deg = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  q15_t out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21, out_m22;

  rot_mat_t expected_mats[$];
  int mismatches = 0;
  bit sending_done = 0;
  bit calm = 0;
  bit hold_long = 0;
  stim_row_t rows[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  axis_angle_to_rotation_matrix_core dut (.*);

  function automatic q15_t round_sat(input logic signed [127:0] e);
    logic signed [127:0] r;
    r = (e + (128'sd1 <<< 44)) >>> 45;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  function automatic rot_mat_t rotation_of(input q15_t ax, ay, az, ang);
    logic signed [127:0] a, x, y, z, dx, dy, c, s, qx, qy, qz, one, at;
    logic signed [127:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic neg_cos;
    rot_mat_t m;
    a = ang;
    neg_cos = 1'b0;
    if (a >= 23040) a = a - 46080;
    else if (a < -23040) a = a + 46080;
    if (a > 11520) begin
      a = 23040 - a;
      neg_cos = 1'b1;
    end else if (a < -11520) begin
      a = -23040 - a;
      neg_cos = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = a * 146409;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
      at = atan_val(i);
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - at;
      end else begin
        x = x + dx; y = y - dy; z = z + at;
      end
    end
    c = neg_cos ? -x : x;
    s = y;
    qx = ($signed(128'(ax)) * s + (128'sd1 <<< 14)) >>> 15;
    qy = ($signed(128'(ay)) * s + (128'sd1 <<< 14)) >>> 15;
    qz = ($signed(128'(az)) * s + (128'sd1 <<< 14)) >>> 15;
    one = 128'sd1 <<< 60;
    xx = 2 * qx * qx; yy = 2 * qy * qy; zz = 2 * qz * qz;
    xy = 2 * qx * qy; xz = 2 * qx * qz; yz = 2 * qy * qz;
    wx = 2 * c * qx; wy = 2 * c * qy; wz = 2 * c * qz;
    m.m00 = round_sat(one - (yy + zz));
    m.m01 = round_sat(xy - wz);
    m.m02 = round_sat(xz + wy);
    m.m10 = round_sat(xy + wz);
    m.m11 = round_sat(one - (xx + zz));
    m.m12 = round_sat(yz - wx);
    m.m20 = round_sat(xz - wy);
    m.m21 = round_sat(yz + wx);
    m.m22 = round_sat(one - (xx + yy));
    return m;
  endfunction

  task automatic send_beat(input q15_t ax, ay, az, ang, input logic has_mat,
                           input rot_mat_t mat);
    rot_mat_t pred;
    pred = rotation_of(ax, ay, az, ang);
    if (has_mat && pred != mat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row mismatch: typed %h predicted %h", mat, pred);
    end
    in_valid <= 1'b1;
    in_axis_x <= ax;
    in_axis_y <= ay;
    in_axis_z <= az;
    in_angle_deg <= ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_mats.push_back(has_mat ? mat : pred);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic add_row(input int ax, ay, az, ang, input int has_mat, input rot_mat_t mat);
    stim_row_t r;
    r.ax = q15_t'(ax); r.ay = q15_t'(ay); r.az = q15_t'(az); r.ang = q15_t'(ang);
    r.has_mat = (has_mat != 0); r.mat = mat;
    rows.push_back(r);
  endtask

  initial begin
    rot_mat_t none;
    q15_t u;
    none = '0;
    add_row(0, 0, 0, 0, 1, IDENT);
    add_row(32767, 0, 0, 0, 0, none);
    add_row(0, 32767, 0, 0, 0, none);
    add_row(0, 0, 32767, 0, 0, none);
    add_row(0, 0, 0, 32767, 0, none);
    add_row(0, 0, 0, -32768, 0, none);
    add_row(32767, 0, 0, 5760, 0, none);
    add_row(0, 32767, 0, -5760, 0, none);
    add_row(0, 0, 32767, 11520, 0, none);
    add_row(32767, 0, 0, 23040, 0, none);
    add_row(0, 32767, 0, 23039, 0, none);
    add_row(0, 0, 32767, -23040, 0, none);
    add_row(0, 0, 32767, -23041, 0, none);
    add_row(32767, 32767, 32767, 11520, 0, none);
    add_row(-32768, -32768, -32768, 11520, 0, none);
    add_row(-32768, -32768, -32768, -32768, 0, none);
    add_row(32767, 32767, 32767, 32767, 0, none);
    add_row(18918, 18918, 18918, 7680, 0, none);
    add_row(-32768, 0, 0, 46079, 0, none);
    add_row(0, -32768, 0, 11521, 0, none);
    add_row(0, 0, -32768, -11521, 0, none);
    add_row(23170, -23170, 0, 2880, 0, none);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_beat(rows[i].ax, rows[i].ay, rows[i].az, rows[i].ang,
                                rows[i].has_mat, rows[i].mat);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 200) hold_long = 1'b1;
      if (n == N_RAND - 200) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: send_beat(q15_t'($urandom), q15_t'($urandom), q15_t'($urandom),
                     q15_t'($urandom), 1'b0, none);
        1: begin
          u = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          send_beat($urandom_range(0, 2) == 0 ? u : q15_t'(0),
                    $urandom_range(0, 2) == 1 ? u : q15_t'(0),
                    $urandom_range(0, 2) == 2 ? u : q15_t'(0), q15_t'($urandom),
                    1'b0, none);
        end
        2: send_beat(q15_t'(int'($urandom_range(0, 37836)) - 18918),
                     q15_t'(int'($urandom_range(0, 37836)) - 18918),
                     q15_t'(int'($urandom_range(0, 37836)) - 18918),
                     q15_t'(int'($urandom_range(0, 46079)) - 23040), 1'b0, none);
        default: send_beat(q15_t'($urandom), q15_t'($urandom), q15_t'($urandom),
                           q15_t'(23040 * (int'($urandom_range(0, 2)) - 1) +
                                  int'($urandom_range(0, 4)) - 2),
                           1'b0, none);
      endcase
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 200) begin
          @(posedge clk);
          hold++;
        end
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rot_mat_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21, out_m22};
      if (expected_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = expected_mats.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("matrix mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    wait (expected_mats.size() == 0);
    repeat (4 * LAT) @(posedge clk);
    if (mismatches == 0 && expected_mats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
